[hdl/pmd_pkg.sv]
package pmd_pkg;

    typedef struct packed {
        logic signed [15:0] position;
        logic [47:0]        timestamp_us;
    } item_t;

    typedef struct packed {
        logic [4:0] duty_reverse;
        logic [4:0] duty_forward;
        logic       last;
    } drive_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd5;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic               loop_enable;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [7:0]         tolerance;
    } cfg_t;

    localparam logic signed [15:0] SETPOINT_RST  = 16'sd1000;
    localparam logic signed [15:0] GAIN_P_RST    = 16'sd256;
    localparam logic [7:0]         TOLERANCE_RST = 8'd2;

    typedef struct packed {
        logic  enabled;
        item_t item;
    } job_t;

    // what the ramp sequencer has to emit for one tick
    typedef struct packed {
        logic       run;
        logic       neg;
        logic [4:0] mapped;
        logic       extra_stop;
    } cmd_t;

    localparam logic [4:0]  DUTY_MIN = 5'd15;
    localparam logic [6:0]  DUTY_CAP = 7'd100;
    localparam logic [19:0] US_PER_S = 20'd1000000;

    localparam int DERIV_BITS = 38;

    // integral / 1e6 as (integral >> 6) / 15625, one 16-bit digit per cycle;
    // each digit quotient is (y * INT_RECIP) >> 44, exact for y < 2^30
    localparam int          INTEG_DIGITS = 4;
    localparam logic [13:0] INT_DIV      = 14'd15625;
    localparam logic [30:0] INT_RECIP    = 31'd1125899907;

    typedef enum logic [3:0] {
        C_IDLE, C_MUL, C_ACC, C_DPREP, C_DDIV, C_IPREP, C_IDIV,
        C_SUM_P, C_SUM_D, C_SUM_I, C_FIN, C_HAND
    } core_state_t;

    typedef enum logic [1:0] {
        R_IDLE, R_RAMP, R_STOP, R_EXTRA
    } ramp_state_t;

    // 15 + duty*15/100, the divide by 100 done as a multiply by 5243 / 2^19
    function automatic logic [4:0] map_duty(input logic [6:0] duty);
        logic [10:0] scaled;
        logic [23:0] prod;
        scaled = 11'(duty) * 11'd15;
        prod   = 24'(scaled) * 24'd5243;
        return DUTY_MIN + prod[23:19];
    endfunction

endpackage

[hdl/pmd_front.sv]
module pmd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  pmd_pkg::item_t                      item_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data,
    output pmd_pkg::cfg_t                       cfg,
    output logic                                job_valid,
    output pmd_pkg::job_t                       job,
    input  logic                                job_ready
);

    pmd_pkg::cfg_t cfg_reg, cfg_next;
    pmd_pkg::job_t q_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;

    assign cfg_ready  = 1'b1;
    assign cfg        = cfg_reg;
    assign item_stall = (count_reg == 2'd2);
    assign job_valid  = (count_reg != 2'd0);
    assign job        = q_mem[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = job_valid && job_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pmd_pkg::CFG_SETPOINT:    cfg_next.setpoint    = cfg_data;
                pmd_pkg::CFG_LOOP_ENABLE: cfg_next.loop_enable = cfg_data[0];
                pmd_pkg::CFG_GAIN_P:      cfg_next.gain_p      = cfg_data;
                pmd_pkg::CFG_GAIN_I:      cfg_next.gain_i      = cfg_data;
                pmd_pkg::CFG_GAIN_D:      cfg_next.gain_d      = cfg_data;
                pmd_pkg::CFG_TOLERANCE:   cfg_next.tolerance   = cfg_data[7:0];
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= pmd_pkg::SETPOINT_RST;
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.gain_p      <= pmd_pkg::GAIN_P_RST;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.tolerance   <= pmd_pkg::TOLERANCE_RST;
            wr_ptr_reg          <= 1'b0;
            rd_ptr_reg          <= 1'b0;
            count_reg           <= 2'd0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classify at entry: snapshot the enable with the tick
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].enabled <= cfg_reg.loop_enable;
            q_mem[wr_ptr_reg].item    <= item_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count overflow");

endmodule

[hdl/pmd_core.sv]
module pmd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  pmd_pkg::cfg_t  cfg,
    input  logic           job_valid,
    input  pmd_pkg::job_t  job,
    output logic           job_ready,
    output logic           cmd_valid,
    output pmd_pkg::cmd_t  cmd,
    input  logic           cmd_ready
);

    pmd_pkg::core_state_t state_reg, state_next;

    logic [47:0]        prev_time_reg, prev_time_next;
    logic signed [17:0] prev_err_reg, prev_err_next;
    logic signed [63:0] integ_reg, integ_next;
    logic signed [15:0] prev_pos_reg, prev_pos_next;

    logic signed [15:0] pos_reg, pos_next;
    logic signed [17:0] err_reg, err_next;
    logic [47:0]        dt_reg, dt_next;
    logic [63:0]        acc_reg, acc_next;
    logic [15:0]        mag_reg, mag_next;
    logic [63:0]        mcand_reg, mcand_next;
    logic [63:0]        num_reg, num_next;
    logic [47:0]        den_reg, den_next;
    logic [47:0]        rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic [6:0]         div_cnt_reg, div_cnt_next;
    logic               qneg_reg, qneg_next;
    logic signed [37:0] deriv_reg, deriv_next;
    logic signed [44:0] iq_reg, iq_next;
    logic signed [63:0] sum_reg, sum_next;
    pmd_pkg::cmd_t      cmd_reg, cmd_next;

    logic [15:0]        err_abs;
    logic [48:0]        trial;
    logic               fits;
    logic               div_last;
    logic signed [63:0] term;
    logic [64:0]        sum65;
    logic signed [18:0] diff;
    logic [17:0]        diff_abs;
    logic [37:0]        dnum;
    logic signed [33:0] p_term;
    logic signed [53:0] d_term;
    logic signed [60:0] i_term;
    logic [63:0]        sum_abs;
    logic [6:0]         duty;
    logic [29:0]        idig;
    logic [60:0]        iprod;
    logic [15:0]        iq_dig;

    assign cmd       = cmd_reg;
    assign err_abs   = err_reg[17] ? 16'(-err_reg) : 16'(err_reg);
    assign trial     = {rem_reg, num_reg[63]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign div_last  = (div_cnt_reg == 7'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmd_pkg::C_IDLE:
                if (job_valid)
                    state_next = job.enabled ? pmd_pkg::C_MUL : pmd_pkg::C_HAND;
            pmd_pkg::C_MUL:
                if (mag_reg == 16'd0)
                    state_next = pmd_pkg::C_ACC;
            pmd_pkg::C_ACC:   state_next = pmd_pkg::C_DPREP;
            pmd_pkg::C_DPREP:
                state_next = (dt_reg == 48'd0) ? pmd_pkg::C_IPREP : pmd_pkg::C_DDIV;
            pmd_pkg::C_DDIV:
                if (div_last)
                    state_next = pmd_pkg::C_IPREP;
            pmd_pkg::C_IPREP: state_next = pmd_pkg::C_IDIV;
            pmd_pkg::C_IDIV:
                if (div_last)
                    state_next = pmd_pkg::C_SUM_P;
            pmd_pkg::C_SUM_P: state_next = pmd_pkg::C_SUM_D;
            pmd_pkg::C_SUM_D: state_next = pmd_pkg::C_SUM_I;
            pmd_pkg::C_SUM_I: state_next = pmd_pkg::C_FIN;
            pmd_pkg::C_FIN:   state_next = pmd_pkg::C_HAND;
            pmd_pkg::C_HAND:
                if (cmd_ready)
                    state_next = pmd_pkg::C_IDLE;
            default:          state_next = pmd_pkg::C_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        job_ready      = 1'b0;
        cmd_valid      = 1'b0;
        prev_time_next = prev_time_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        prev_pos_next  = prev_pos_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        mcand_next     = mcand_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        qneg_next      = qneg_reg;
        deriv_next     = deriv_reg;
        iq_next        = iq_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        term           = '0;
        sum65          = '0;
        diff           = '0;
        diff_abs       = '0;
        dnum           = '0;
        p_term         = '0;
        d_term         = '0;
        i_term         = '0;
        sum_abs        = '0;
        duty           = '0;
        idig           = '0;
        iprod          = '0;
        iq_dig         = '0;

        case (state_reg)
            pmd_pkg::C_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    if (!job.enabled)
                    begin
                        cmd_next.run        = 1'b0;
                        cmd_next.neg        = 1'b0;
                        cmd_next.mapped     = pmd_pkg::DUTY_MIN;
                        cmd_next.extra_stop = 1'b0;
                    end
                    else
                    begin
                        pos_next       = job.item.position;
                        err_next       = {{2{job.item.position[15]}}, job.item.position}
                                       - {{2{cfg.setpoint[15]}}, cfg.setpoint};
                        dt_next        = job.item.timestamp_us - prev_time_reg;
                        prev_time_next = job.item.timestamp_us;
                        mag_next       = err_next[17] ? 16'(-err_next) : 16'(err_next);
                        mcand_next     = {16'd0, dt_next};
                        acc_next       = '0;
                    end
                end
            end

            // shift-add |error| * dt, one multiplier bit per cycle
            pmd_pkg::C_MUL:
            begin
                if (mag_reg != 16'd0)
                begin
                    if (mag_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mag_next   = mag_reg >> 1;
                    mcand_next = mcand_reg << 1;
                end
            end

            // saturate the product, then saturating add into the integral
            pmd_pkg::C_ACC:
            begin
                if (acc_reg[63])
                    term = err_reg[17] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    term = err_reg[17] ? -$signed(acc_reg) : $signed(acc_reg);
                sum65 = {integ_reg[63], integ_reg} + {term[63], term};
                if (sum65[64] != sum65[63])
                    integ_next = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    integ_next = sum65[63:0];
            end

            pmd_pkg::C_DPREP:
            begin
                diff          = {err_reg[17], err_reg} - {prev_err_reg[17], prev_err_reg};
                diff_abs      = diff[18] ? 18'(-diff) : 18'(diff);
                dnum          = 38'(diff_abs) * 38'(pmd_pkg::US_PER_S);
                prev_err_next = err_reg;
                deriv_next    = '0;
                num_next      = {dnum, (64 - pmd_pkg::DERIV_BITS)'(0)};
                den_next      = dt_reg;
                rem_next      = '0;
                quo_next      = '0;
                div_cnt_next  = 7'(pmd_pkg::DERIV_BITS);
                qneg_next     = diff[18];
            end

            pmd_pkg::C_DDIV:
            begin
                rem_next     = fits ? 48'(trial - {1'b0, den_reg}) : trial[47:0];
                quo_next     = {quo_reg[62:0], fits};
                num_next     = num_reg << 1;
                div_cnt_next = div_cnt_reg - 7'd1;
            end

            // 1e6 = 64 * 15625: drop six bits, then divide by 15625 digit by digit
            pmd_pkg::C_IPREP:
            begin
                if (dt_reg != 48'd0)
                    deriv_next = qneg_reg ? -$signed(quo_reg[37:0]) : $signed(quo_reg[37:0]);
                num_next     = integ_reg[63] ? 64'(-integ_reg) >> 6 : 64'(integ_reg) >> 6;
                rem_next     = '0;
                quo_next     = '0;
                div_cnt_next = 7'(pmd_pkg::INTEG_DIGITS);
                qneg_next    = integ_reg[63];
            end

            pmd_pkg::C_IDIV:
            begin
                idig         = {rem_reg[13:0], num_reg[63:48]};
                iprod        = 61'(idig) * 61'(pmd_pkg::INT_RECIP);
                iq_dig       = iprod[59:44];
                rem_next     = 48'(idig - 30'(iq_dig) * 30'(pmd_pkg::INT_DIV));
                quo_next     = {quo_reg[47:0], iq_dig};
                num_next     = num_reg << 16;
                div_cnt_next = div_cnt_reg - 7'd1;
            end

            pmd_pkg::C_SUM_P:
            begin
                iq_next  = qneg_reg ? -$signed(quo_reg[44:0]) : $signed(quo_reg[44:0]);
                p_term   = cfg.gain_p * err_reg;
                sum_next = 64'(p_term);
            end

            pmd_pkg::C_SUM_D:
            begin
                d_term   = cfg.gain_d * deriv_reg;
                sum_next = sum_reg + 64'(d_term);
            end

            pmd_pkg::C_SUM_I:
            begin
                i_term   = cfg.gain_i * iq_reg;
                sum_next = sum_reg + 64'(i_term);
            end

            pmd_pkg::C_FIN:
            begin
                sum_abs = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
                if (sum_abs[63:8] > 56'(pmd_pkg::DUTY_CAP))
                    duty = pmd_pkg::DUTY_CAP;
                else
                    duty = sum_abs[14:8];
                if (err_abs <= 16'(cfg.tolerance))
                    duty = '0;
                cmd_next.run        = (duty != 7'd0);
                cmd_next.neg        = sum_reg[63];
                cmd_next.mapped     = pmd_pkg::map_duty(duty);
                cmd_next.extra_stop = (pos_reg == prev_pos_reg);
                if (pos_reg != prev_pos_reg)
                    prev_pos_next = pos_reg;
            end

            pmd_pkg::C_HAND:
                cmd_valid = 1'b1;

            default:
                cmd_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmd_pkg::C_IDLE;
            prev_time_reg <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            prev_pos_reg  <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_time_reg <= prev_time_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            prev_pos_reg  <= prev_pos_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        dt_reg    <= dt_next;
        acc_reg   <= acc_next;
        mag_reg   <= mag_next;
        mcand_reg <= mcand_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        qneg_reg  <= qneg_next;
        deriv_reg <= deriv_next;
        iq_reg    <= iq_next;
        sum_reg   <= sum_next;
        cmd_reg   <= cmd_next;
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmd_pkg::C_DDIV || state_reg == pmd_pkg::C_IDIV) |-> div_cnt_reg != 7'd0)
        else $error("divider running with zero count");

    a_zero_dt_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmd_pkg::C_DDIV) |-> dt_reg != 48'd0)
        else $error("derivative divide with zero dt");

endmodule

[hdl/pmd_ramp.sv]
module pmd_ramp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  pmd_pkg::cmd_t   cmd,
    output logic            cmd_ready,
    output logic            drive_valid,
    input  logic            drive_stall,
    output pmd_pkg::drive_t drive_data
);

    pmd_pkg::ramp_state_t state_reg, state_next;
    pmd_pkg::cmd_t        cmd_reg, cmd_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 ov_reg, ov_next;
    pmd_pkg::drive_t      od_reg, od_next;
    pmd_pkg::drive_t      emit;
    logic                 load;
    logic                 ramp_end;

    assign load        = (state_reg != pmd_pkg::R_IDLE) && (!ov_reg || !drive_stall);
    assign ramp_end    = (cnt_reg == cmd_reg.mapped);
    assign drive_valid = ov_reg;
    assign drive_data  = od_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmd_pkg::R_IDLE:
                if (cmd_valid)
                    state_next = cmd.run ? pmd_pkg::R_RAMP : pmd_pkg::R_STOP;
            pmd_pkg::R_RAMP:
                if (load && ramp_end)
                    state_next = cmd_reg.extra_stop ? pmd_pkg::R_EXTRA : pmd_pkg::R_IDLE;
            pmd_pkg::R_STOP:
                if (load)
                    state_next = cmd_reg.extra_stop ? pmd_pkg::R_EXTRA : pmd_pkg::R_IDLE;
            pmd_pkg::R_EXTRA:
                if (load)
                    state_next = pmd_pkg::R_IDLE;
            default:
                state_next = pmd_pkg::R_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        cmd_next  = cmd_reg;
        cnt_next  = cnt_reg;
        emit      = '0;
        case (state_reg)
            pmd_pkg::R_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    cnt_next = pmd_pkg::DUTY_MIN;
                end
            end
            pmd_pkg::R_RAMP:
            begin
                if (cmd_reg.neg)
                    emit.duty_reverse = cnt_reg;
                else
                    emit.duty_forward = cnt_reg;
                emit.last = ramp_end && !cmd_reg.extra_stop;
                if (load && !ramp_end)
                    cnt_next = cnt_reg + 5'd1;
            end
            pmd_pkg::R_STOP:
                emit.last = !cmd_reg.extra_stop;
            pmd_pkg::R_EXTRA:
                emit.last = 1'b1;
            default:
                emit = '0;
        endcase
    end

    // result register: hold while stalled
    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (load)
        begin
            ov_next = 1'b1;
            od_next = emit;
        end
        else if (!drive_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmd_pkg::R_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        cnt_reg <= cnt_next;
        od_reg  <= od_next;
    end

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && emit.last) |=> state_reg == pmd_pkg::R_IDLE)
        else $error("sequencer busy after final result");

    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmd_pkg::R_RAMP) |-> (cnt_reg >= pmd_pkg::DUTY_MIN && cnt_reg <= cmd_reg.mapped))
        else $error("ramp duty out of range");

endmodule

[hdl/pid_position_motor_drive.sv]
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// item     | item_valid / item_stall   | item_data  (position, timestamp_us)
// drive    | drive_valid / drive_stall | drive_data (duty_reverse, duty_forward, last)
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// In the control core a disabled tick goes straight from idle to the handoff; an enabled tick's
// time is set by the shift-add multiplier (which shifts |error| down until it is zero),
// the one-bit-per-cycle derivative divider (38 steps, skipped when dt is zero)
// and the 4-digit integral scaling.
// Results leave at one per cycle from the ramp sequencer while drive is not stalled.
// Reset clears state and loads register defaults at once; no clearing pass.
// A two-entry queue takes ticks while the core works; drive_stall holds the result register.
module pid_position_motor_drive (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  pmd_pkg::item_t                item_data,
    output logic                          drive_valid,
    input  logic                          drive_stall,
    output pmd_pkg::drive_t               drive_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    pmd_pkg::cfg_t cfg;
    pmd_pkg::job_t job;
    pmd_pkg::cmd_t cmd;
    logic          job_valid, job_ready;
    logic          cmd_valid, cmd_ready;

    pmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready)
    );

    pmd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    pmd_ramp u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_data  (drive_data)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SAT_MIN = -64'sh7fff_ffff_ffff_ffff - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    pmd_pkg::item_t                item_data;
    logic                          drive_valid;
    logic                          drive_stall;
    pmd_pkg::drive_t               drive_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;

    pid_position_motor_drive dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item_data(item_data),
        .drive_valid(drive_valid), .drive_stall(drive_stall), .drive_data(drive_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // controller mirror: registers and loop state
    logic signed [15:0] ctl_setpoint;
    logic               ctl_enable;
    logic signed [15:0] ctl_kp, ctl_ki, ctl_kd;
    logic [7:0]         ctl_tol;
    logic [47:0]        ctl_prev_time;
    longint             ctl_prev_err;
    longint             ctl_integ;
    logic signed [15:0] ctl_prev_pos;

    pmd_pkg::item_t  pending_ticks[$];
    pmd_pkg::drive_t expected_drive[$];

    int  mismatches = 0;
    int  ticks_sent = 0;
    int  drives_seen = 0;
    int  ramps_seen = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  stall_hold = 0;
    bit  idling_on = 1;
    bit  long_hold_go = 0;
    bit  long_hold_used = 0;
    logic [47:0] clock_us = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic void apply_reg(logic [pmd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            pmd_pkg::CFG_SETPOINT:    ctl_setpoint = val;
            pmd_pkg::CFG_LOOP_ENABLE: ctl_enable = val[0];
            pmd_pkg::CFG_GAIN_P:      ctl_kp = val;
            pmd_pkg::CFG_GAIN_I:      ctl_ki = val;
            pmd_pkg::CFG_GAIN_D:      ctl_kd = val;
            pmd_pkg::CFG_TOLERANCE:   ctl_tol = val[7:0];
            default: ;
        endcase
    endfunction

    // work out the drive commands for one control tick
    function automatic void predict_drive(pmd_pkg::item_t tick);
        logic [47:0]     dt;
        longint          err, deriv, prod, sum, dt_l;
        longint unsigned emag, mag, duty, mapped;
        bit              neg;
        pmd_pkg::drive_t cmds[$];
        pmd_pkg::drive_t cmd;
        if (!ctl_enable)
        begin
            cmd = '0;
            cmd.last = 1'b1;
            expected_drive.push_back(cmd);
            return;
        end
        dt = tick.timestamp_us - ctl_prev_time;
        ctl_prev_time = tick.timestamp_us;
        dt_l = longint'({16'd0, dt});
        err = longint'(tick.position) - longint'(ctl_setpoint);
        deriv = (dt == 0) ? 0 : ((err - ctl_prev_err) * 1000000) / dt_l;
        emag = (err < 0) ? -err : err;
        if (emag != 0 && longint'(dt_l) > SAT_MAX / longint'(emag))
            prod = (err < 0) ? SAT_MIN : SAT_MAX;
        else
            prod = err * dt_l;
        if (prod > 0 && ctl_integ > SAT_MAX - prod)
            ctl_integ = SAT_MAX;
        else if (prod < 0 && ctl_integ < SAT_MIN - prod)
            ctl_integ = SAT_MIN;
        else
            ctl_integ = ctl_integ + prod;
        ctl_prev_err = err;
        sum = longint'(ctl_kp) * err + longint'(ctl_kd) * deriv
            + longint'(ctl_ki) * (ctl_integ / 1000000);
        neg = sum < 0;
        mag = neg ? -sum : sum;
        duty = mag >> 8;
        if (duty > 100)
            duty = 100;
        if (emag <= ctl_tol)
            duty = 0;
        if (duty == 0)
            cmds.push_back('0);
        else
        begin
            mapped = duty * 15 / 100 + 15;
            for (longint unsigned d = 15; d <= mapped; d++)
            begin
                cmd = '0;
                if (neg)
                    cmd.duty_reverse = d[4:0];
                else
                    cmd.duty_forward = d[4:0];
                cmds.push_back(cmd);
            end
            ramps_seen++;
        end
        if (tick.position == ctl_prev_pos)
            cmds.push_back('0);
        else
            ctl_prev_pos = tick.position;
        cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i])
            expected_drive.push_back(cmds[i]);
    endfunction

    // driver: present queued ticks, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_data <= '0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_drive(item_data);
                ticks_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    item_valid <= 1'b1;
                    item_data <= pending_ticks.pop_front();
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: check drive commands, generate stall
    always @(posedge clk or negedge rst_n)
    begin
        pmd_pkg::drive_t want;
        if (!rst_n)
        begin
            drive_stall <= 1'b0;
            stall_hold = 0;
        end
        else
        begin
            if (drive_valid && !drive_stall)
            begin
                drives_seen++;
                if (expected_drive.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected drive transaction rev=%0d fwd=%0d last=%0d",
                                 drive_data.duty_reverse, drive_data.duty_forward,
                                 drive_data.last);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (drive_data.duty_reverse !== want.duty_reverse
                        || drive_data.duty_forward !== want.duty_forward
                        || drive_data.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: drive mismatch exp rev=%0d fwd=%0d last=%0d,",
                                      " got rev=%0d fwd=%0d last=%0d"},
                                     want.duty_reverse, want.duty_forward, want.last,
                                     drive_data.duty_reverse, drive_data.duty_forward,
                                     drive_data.last);
                    end
                end
            end
            if (long_hold_go && !long_hold_used)
            begin
                long_hold_used = 1;
                stall_hold = 400;
            end
            if (stall_hold > 0)
            begin
                stall_hold--;
                drive_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_hold = $urandom_range(0, 14);
                drive_stall <= 1'b1;
            end
            else
                drive_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (drive_valid && !drive_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: watchdog timeout, %0d results outstanding",
                         expected_drive.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [pmd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || item_valid || expected_drive.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_tick(logic signed [15:0] pos, logic [47:0] ts);
        pmd_pkg::item_t t;
        t.position = pos;
        t.timestamp_us = ts;
        pending_ticks.push_back(t);
    endtask

    function automatic logic [47:0] rand_ts48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // mostly well-formed ticks near the setpoint with advancing time
    task automatic queue_random(int count);
        logic signed [15:0] pos;
        logic signed [15:0] last_pos;
        last_pos = ctl_setpoint;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0: pos = 16'($urandom());
                1: pos = last_pos;
                2: pos = ctl_setpoint + $signed(16'($urandom_range(0, 8))) - 16'sd4;
                default: pos = ctl_setpoint + $signed(16'($urandom_range(0, 600))) - 16'sd300;
            endcase
            case ($urandom_range(0, 15))
                0: clock_us = rand_ts48();
                1: clock_us = clock_us;
                2: clock_us = clock_us - 48'($urandom_range(1, 5000));
                default: clock_us = clock_us + 48'($urandom_range(1, 3000));
            endcase
            queue_tick(pos, clock_us);
            last_pos = pos;
        end
    endtask

    task automatic random_config(bit extremes);
        logic [15:0] gp, gi, gd;
        if (extremes)
        begin
            gp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            gi = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            gd = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        end
        else
        begin
            gp = $urandom_range(0, 3) == 0 ? 16'($urandom())
                                           : 16'($urandom_range(0, 2048)) - 16'd1024;
            gi = $urandom_range(0, 3) == 0 ? 16'($urandom())
                                           : 16'($urandom_range(0, 64)) - 16'd32;
            gd = $urandom_range(0, 3) == 0 ? 16'($urandom())
                                           : 16'($urandom_range(0, 16)) - 16'd8;
        end
        write_reg(pmd_pkg::CFG_SETPOINT, 16'($urandom()));
        write_reg(pmd_pkg::CFG_GAIN_P, gp);
        write_reg(pmd_pkg::CFG_GAIN_I, gi);
        write_reg(pmd_pkg::CFG_GAIN_D, gd);
        write_reg(pmd_pkg::CFG_TOLERANCE, {8'($urandom()), 8'($urandom_range(0, 255))});
        write_reg(pmd_pkg::CFG_LOOP_ENABLE, {15'($urandom()), 1'b1});
    endtask

    initial
    begin
        ctl_setpoint = pmd_pkg::SETPOINT_RST;
        ctl_enable = 1'b0;
        ctl_kp = pmd_pkg::GAIN_P_RST;
        ctl_ki = '0;
        ctl_kd = '0;
        ctl_tol = pmd_pkg::TOLERANCE_RST;
        ctl_prev_time = '0;
        ctl_prev_err = 0;
        ctl_integ = 0;
        ctl_prev_pos = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // loop disabled out of reset: every tick is a single stop
        queue_tick(16'sh7fff, 48'd0);
        queue_tick(-16'sh8000, 48'hffff_ffff_ffff);
        queue_tick(16'sd1000, 48'd100);
        drain();

        // reset gains, loop on: both directions, tolerance, repeats, dt edge cases
        write_reg(pmd_pkg::CFG_LOOP_ENABLE, 16'd1);
        queue_tick(16'sd1000, 48'd1000);
        queue_tick(16'sd1002, 48'd2000);
        queue_tick(16'sd1003, 48'd2000);
        queue_tick(16'sd1003, 48'd3000);
        queue_tick(16'sd1200, 48'd4000);
        queue_tick(16'sd700, 48'd5000);
        queue_tick(16'sh7fff, 48'd6000);
        queue_tick(-16'sh8000, 48'd7000);
        queue_tick(-16'sh8000, 48'd500);
        queue_tick(16'sd0, 48'hffff_ffff_ffff);
        queue_tick(16'sd1101, 48'hffff_ffff_ffff);
        drain();

        // all gains at the largest magnitudes, integral pushed toward saturation
        write_reg(pmd_pkg::CFG_GAIN_P, 16'h8000);
        write_reg(pmd_pkg::CFG_GAIN_I, 16'h7fff);
        write_reg(pmd_pkg::CFG_GAIN_D, 16'h7fff);
        write_reg(pmd_pkg::CFG_TOLERANCE, 16'd255);
        write_reg(pmd_pkg::CFG_SETPOINT, 16'h8000);
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'h1234);
        queue_tick(16'sh7fff, 48'h8000_0000_0000);
        queue_tick(16'sh7fff, 48'h0000_0000_0001);
        queue_tick(-16'sh7f00, 48'h0000_0000_0002);
        queue_tick(-16'sh8000, 48'h7fff_ffff_ffff);
        queue_tick(16'sd200, 48'h7fff_ffff_ffff);
        drain();
        write_reg(pmd_pkg::CFG_TOLERANCE, 16'd0);
        write_reg(pmd_pkg::CFG_SETPOINT, 16'h7fff);
        queue_tick(16'sh7fff, 48'h7fff_ffff_fff0);
        queue_tick(16'sh7ffe, 48'h7fff_ffff_fff1);
        drain();

        // random phases; one of them with the receiver holding off for a long stretch
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 5)
                write_reg(pmd_pkg::CFG_LOOP_ENABLE, 16'd0);
            else
                random_config(ph == 3);
            if (ph == 2)
                long_hold_go = 1;
            if (ph == 7)
                idling_on = 0;
            queue_random(60);
            drain();
        end

        $display("Run covered %0d ticks and %0d drive commands (%0d ramps) over",
                 ticks_sent, drives_seen, ramps_seen);
        $display("disabled, saturated-gain, wrapped-time and random-gain phases.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
